@@ rtl/x86enc_pkg.sv @@
// Package with the types, constants and helper functions of the x86-64 instruction encoder.
`timescale 1ns / 1ps
package x86enc_pkg;

  localparam int unsigned MaxBytes = 10;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  typedef enum logic [4:0] {
    OP_MOV_IMM  = 5'd0,
    OP_MOV_RR   = 5'd1,
    OP_LOAD     = 5'd2,
    OP_STORE    = 5'd3,
    OP_LEA      = 5'd4,
    OP_PUSH     = 5'd5,
    OP_POP      = 5'd6,
    OP_ADD_IMM  = 5'd7,
    OP_SUB_IMM  = 5'd8,
    OP_ADD_RR   = 5'd9,
    OP_SUB_RR   = 5'd10,
    OP_IMUL     = 5'd11,
    OP_CMP      = 5'd12,
    OP_TEST     = 5'd13,
    OP_SETCC    = 5'd14,
    OP_NEG      = 5'd15,
    OP_CQO      = 5'd16,
    OP_IDIV     = 5'd17,
    OP_CALL     = 5'd18,
    OP_JMP      = 5'd19,
    OP_JCC      = 5'd20,
    OP_RET      = 5'd21,
    OP_SYSCALL  = 5'd22
  } opcode_e;

  localparam logic [7:0] REX_BASE    = 8'h40;
  localparam logic [7:0] REX_W       = 8'h08;
  localparam logic [7:0] REX_B_ONLY  = 8'h41;
  localparam logic [7:0] REX_W_ONLY  = 8'h48;
  localparam logic [7:0] OPC_MOV_IMM = 8'hB8;
  localparam logic [7:0] OPC_ESCAPE  = 8'h0F;
  localparam logic [7:0] OPC_IMUL2   = 8'hAF;
  localparam logic [7:0] OPC_SETCC   = 8'h90;
  localparam logic [7:0] OPC_MOVZX2  = 8'hB6;
  localparam logic [7:0] OPC_GRP1    = 8'h81;
  localparam logic [7:0] OPC_CQO     = 8'h99;
  localparam logic [7:0] OPC_CALL    = 8'hE8;
  localparam logic [7:0] OPC_JMP     = 8'hE9;
  localparam logic [7:0] OPC_RET     = 8'hC3;
  localparam logic [7:0] OPC_JCC2    = 8'h80;
  localparam logic [7:0] OPC_MOV_ST  = 8'h89;
  localparam logic [7:0] OPC_MOV_LD  = 8'h8B;
  localparam logic [7:0] OPC_LEA     = 8'h8D;
  localparam logic [7:0] OPC_PUSH    = 8'h50;
  localparam logic [7:0] OPC_POP     = 8'h58;
  localparam logic [7:0] OPC_ADD     = 8'h01;
  localparam logic [7:0] OPC_SUB     = 8'h29;
  localparam logic [7:0] OPC_CMP     = 8'h39;
  localparam logic [7:0] OPC_TEST    = 8'h85;
  localparam logic [7:0] OPC_GRP3    = 8'hF7;
  localparam logic [7:0] OPC_SYSCALL = 8'h05;

  localparam logic [3:0] RM_RBP  = 4'd5;
  localparam logic [2:0] EXT_ADD = 3'd0;
  localparam logic [2:0] EXT_SUB = 3'd5;
  localparam logic [2:0] EXT_NEG = 3'd3;
  localparam logic [2:0] EXT_IDV = 3'd7;

  localparam logic [1:0] MOD_IND    = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  typedef struct packed {
    logic [4:0]         opcode;
    logic [3:0]         dst_reg;
    logic [3:0]         src_reg;
    logic [2:0]         condition;
    logic signed [63:0] immediate;
    logic signed [31:0] frame_offset;
    logic signed [31:0] rel_displacement;
  } item_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
    logic                     error;
  } enc_t;

  function automatic logic [7:0] rex(input logic w, input logic [3:0] reg_f,
                                     input logic [3:0] rm_f);
    return REX_BASE | (w ? REX_W : 8'h00) | {5'b0, reg_f[3], 1'b0, rm_f[3]};
  endfunction

  function automatic logic [7:0] modrm(input logic [1:0] mod_f, input logic [2:0] reg_f,
                                       input logic [2:0] rm_f);
    return {mod_f, reg_f, rm_f};
  endfunction

  // Low nibble of the condition code; e and z, ne and nz share an encoding.
  function automatic logic [7:0] cc_suffix(input logic [2:0] c);
    logic [7:0] r;
    case (c)
      3'd0, 3'd1: r = 8'h04;
      3'd2, 3'd3: r = 8'h05;
      3'd4:       r = 8'h0C;
      3'd5:       r = 8'h0D;
      3'd6:       r = 8'h0E;
      default:    r = 8'h0F;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/x86enc_if.sv @@
// Valid/ready channel interfaces for instruction items and machine code bytes.
`timescale 1ns / 1ps
interface x86enc_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         opcode;
  logic [3:0]         dst_reg;
  logic [3:0]         src_reg;
  logic [2:0]         condition;
  logic signed [63:0] immediate;
  logic signed [31:0] frame_offset;
  logic signed [31:0] rel_displacement;

  modport source (output valid, opcode, dst_reg, src_reg, condition, immediate,
                  frame_offset, rel_displacement, input ready);
  modport sink   (input valid, opcode, dst_reg, src_reg, condition, immediate,
                  frame_offset, rel_displacement, output ready);
endinterface

interface x86enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink   (input valid, out_byte, last, error, output ready);
endinterface

@@ rtl/x86enc_encoder.sv @@
// Combinational encoder that turns one instruction item into its byte string and length.
`timescale 1ns / 1ps
module x86enc_encoder (
  input  x86enc_pkg::item_t item_i,
  output x86enc_pkg::enc_t  enc_o
);
  import x86enc_pkg::*;

  logic [3:0]       d;
  logic [3:0]       s;
  logic [7:0]       cc;
  logic             disp_small;
  logic [1:0]       disp_mod;
  logic [6:0][7:0]  sc_body;
  logic             sc_pfx;
  logic [7:0]       sc_pfx_byte;

  assign d  = item_i.dst_reg;
  assign s  = item_i.src_reg;
  assign cc = cc_suffix(item_i.condition);

  // The offset fits a signed byte when bits 31..7 are all equal.
  assign disp_small = (item_i.frame_offset[31:7] == '0) || (item_i.frame_offset[31:7] == '1);
  assign disp_mod   = disp_small ? MOD_DISP8 : MOD_DISP32;

  always_comb begin
    sc_body[0] = OPC_ESCAPE;
    sc_body[1] = OPC_SETCC + cc;
    sc_body[2] = modrm(MOD_REG, 3'd0, d[2:0]);
    sc_body[3] = rex(1'b1, d, d);
    sc_body[4] = OPC_ESCAPE;
    sc_body[5] = OPC_MOVZX2;
    sc_body[6] = modrm(MOD_REG, d[2:0], d[2:0]);
    // Byte registers 4 to 7 need a plain REX to mean spl..dil, not ah..bh.
    if (d inside {[4'd4:4'd7]}) begin
      sc_pfx      = 1'b1;
      sc_pfx_byte = REX_BASE;
    end else begin
      sc_pfx      = d[3];
      sc_pfx_byte = REX_B_ONLY;
    end
  end

  always_comb begin
    enc_o       = '0;
    case (opcode_e'(item_i.opcode))
      OP_MOV_IMM: begin
        enc_o.bytes[0]   = rex(1'b1, 4'd0, d);
        enc_o.bytes[1]   = OPC_MOV_IMM + {5'b0, d[2:0]};
        enc_o.bytes[9:2] = item_i.immediate;
        enc_o.count      = CntW'(10);
      end
      OP_MOV_RR, OP_ADD_RR, OP_SUB_RR, OP_CMP, OP_TEST: begin
        enc_o.bytes[0] = rex(1'b1, s, d);
        case (opcode_e'(item_i.opcode))
          OP_MOV_RR: enc_o.bytes[1] = OPC_MOV_ST;
          OP_ADD_RR: enc_o.bytes[1] = OPC_ADD;
          OP_SUB_RR: enc_o.bytes[1] = OPC_SUB;
          OP_CMP:    enc_o.bytes[1] = OPC_CMP;
          default:   enc_o.bytes[1] = OPC_TEST;
        endcase
        enc_o.bytes[2] = modrm(MOD_REG, s[2:0], d[2:0]);
        enc_o.count    = CntW'(3);
      end
      OP_LOAD, OP_STORE: begin
        if (opcode_e'(item_i.opcode) == OP_LOAD) begin
          enc_o.bytes[0] = rex(1'b1, d, RM_RBP);
          enc_o.bytes[1] = OPC_MOV_LD;
          enc_o.bytes[2] = modrm(disp_mod, d[2:0], RM_RBP[2:0]);
        end else begin
          enc_o.bytes[0] = rex(1'b1, s, RM_RBP);
          enc_o.bytes[1] = OPC_MOV_ST;
          enc_o.bytes[2] = modrm(disp_mod, s[2:0], RM_RBP[2:0]);
        end
        if (disp_small) begin
          enc_o.bytes[3] = item_i.frame_offset[7:0];
          enc_o.count    = CntW'(4);
        end else begin
          enc_o.bytes[6:3] = item_i.frame_offset;
          enc_o.count      = CntW'(7);
        end
      end
      OP_LEA: begin
        enc_o.bytes[0]   = rex(1'b1, d, RM_RBP);
        enc_o.bytes[1]   = OPC_LEA;
        enc_o.bytes[2]   = modrm(MOD_IND, d[2:0], RM_RBP[2:0]);
        enc_o.bytes[6:3] = item_i.rel_displacement;
        enc_o.count      = CntW'(7);
      end
      OP_PUSH: begin
        if (s[3]) begin
          enc_o.bytes[0] = REX_B_ONLY;
          enc_o.bytes[1] = OPC_PUSH + {5'b0, s[2:0]};
          enc_o.count    = CntW'(2);
        end else begin
          enc_o.bytes[0] = OPC_PUSH + {5'b0, s[2:0]};
          enc_o.count    = CntW'(1);
        end
      end
      OP_POP: begin
        if (d[3]) begin
          enc_o.bytes[0] = REX_B_ONLY;
          enc_o.bytes[1] = OPC_POP + {5'b0, d[2:0]};
          enc_o.count    = CntW'(2);
        end else begin
          enc_o.bytes[0] = OPC_POP + {5'b0, d[2:0]};
          enc_o.count    = CntW'(1);
        end
      end
      OP_ADD_IMM, OP_SUB_IMM: begin
        enc_o.bytes[0]   = rex(1'b1, 4'd0, d);
        enc_o.bytes[1]   = OPC_GRP1;
        enc_o.bytes[2]   = modrm(MOD_REG,
                                 (opcode_e'(item_i.opcode) == OP_ADD_IMM) ? EXT_ADD : EXT_SUB,
                                 d[2:0]);
        enc_o.bytes[6:3] = item_i.immediate[31:0];
        enc_o.count      = CntW'(7);
      end
      OP_IMUL: begin
        enc_o.bytes[0] = rex(1'b1, d, s);
        enc_o.bytes[1] = OPC_ESCAPE;
        enc_o.bytes[2] = OPC_IMUL2;
        enc_o.bytes[3] = modrm(MOD_REG, d[2:0], s[2:0]);
        enc_o.count    = CntW'(4);
      end
      OP_SETCC: begin
        if (sc_pfx) begin
          enc_o.bytes[0]   = sc_pfx_byte;
          enc_o.bytes[7:1] = sc_body;
          enc_o.count      = CntW'(8);
        end else begin
          enc_o.bytes[6:0] = sc_body;
          enc_o.count      = CntW'(7);
        end
      end
      OP_NEG: begin
        enc_o.bytes[0] = rex(1'b1, 4'd0, d);
        enc_o.bytes[1] = OPC_GRP3;
        enc_o.bytes[2] = modrm(MOD_REG, EXT_NEG, d[2:0]);
        enc_o.count    = CntW'(3);
      end
      OP_CQO: begin
        enc_o.bytes[0] = REX_W_ONLY;
        enc_o.bytes[1] = OPC_CQO;
        enc_o.count    = CntW'(2);
      end
      OP_IDIV: begin
        enc_o.bytes[0] = rex(1'b1, 4'd0, s);
        enc_o.bytes[1] = OPC_GRP3;
        enc_o.bytes[2] = modrm(MOD_REG, EXT_IDV, s[2:0]);
        enc_o.count    = CntW'(3);
      end
      OP_CALL, OP_JMP: begin
        enc_o.bytes[0]   = (opcode_e'(item_i.opcode) == OP_CALL) ? OPC_CALL : OPC_JMP;
        enc_o.bytes[4:1] = item_i.rel_displacement;
        enc_o.count      = CntW'(5);
      end
      OP_JCC: begin
        enc_o.bytes[0]   = OPC_ESCAPE;
        enc_o.bytes[1]   = OPC_JCC2 + cc;
        enc_o.bytes[5:2] = item_i.rel_displacement;
        enc_o.count      = CntW'(6);
      end
      OP_RET: begin
        enc_o.bytes[0] = OPC_RET;
        enc_o.count    = CntW'(1);
      end
      OP_SYSCALL: begin
        enc_o.bytes[0] = OPC_ESCAPE;
        enc_o.bytes[1] = OPC_SYSCALL;
        enc_o.count    = CntW'(2);
      end
      default: begin
        // Reserved opcode: a single zero byte flagged as an error.
        enc_o.count = CntW'(1);
        enc_o.error = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/x86enc_serializer.sv @@
// Result register that holds one encoded instruction and shifts it out a byte per transaction.
`timescale 1ns / 1ps
module x86enc_serializer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  x86enc_pkg::enc_t     enc_i,
  input  logic                 enc_vld_i,
  output logic                 enc_rdy_o,
  x86enc_out_if.source         out_o
);
  import x86enc_pkg::*;

  logic [MaxBytes-1:0][7:0] buf_q, buf_d;
  logic [CntW-1:0]          rem_q, rem_d;
  logic                     err_q, err_d;
  logic                     vld_q, vld_d;
  logic                     take;
  logic                     is_last;
  logic                     load;

  assign is_last   = (rem_q == CntW'(1));
  assign take      = vld_q && out_o.ready;
  assign enc_rdy_o = !vld_q || (take && is_last);
  assign load      = enc_vld_i && enc_rdy_o;

  assign out_o.valid    = vld_q;
  assign out_o.out_byte = buf_q[0];
  assign out_o.last     = is_last;
  assign out_o.error    = err_q;

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    err_d = err_q;
    vld_d = vld_q;
    if (load) begin
      buf_d = enc_i.bytes;
      rem_d = enc_i.count;
      err_d = enc_i.error;
      vld_d = 1'b1;
    end else if (take) begin
      buf_d = {8'h00, buf_q[MaxBytes-1:1]};
      rem_d = rem_q - CntW'(1);
      vld_d = !is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      rem_q <= '0;
    end else begin
      vld_q <= vld_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    err_q <= err_d;
  end

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (rem_q != '0) && (rem_q <= CntW'(MaxBytes)))
    else $error("byte count out of range while holding an instruction");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && err_q) |-> (is_last && (buf_q[0] == 8'h00)))
    else $error("error transaction is not a single zero byte");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !is_last) |=> (vld_q && (rem_q == $past(rem_q) - CntW'(1))))
    else $error("byte count did not step down after a transaction");

endmodule

@@ rtl/x86_64_instruction_encoder_top.sv @@
// Top level of the x86-64 instruction encoder: input register, encoder and byte serializer.
//
//   Channel  Direction  Moves                      Accepted when
//   req_i    in         one abstract instruction   req_i.valid && req_i.ready
//   rsp_o    out        one machine code byte      rsp_o.valid && rsp_o.ready
//
// An accepted instruction sits in the input register, is encoded by
// combinational logic and lands in the result register, which sends one byte per
// transaction. An instruction of n bytes (1 to 10, mov with imm64 being the longest)
// occupies the output for n byte transactions, so the byte port sets the rate; the next
// instruction loads in the same cycle as the previous last byte leaves.
// The first byte appears once the item has passed both registers. Reset is asynchronous
// and active low and empties both registers. A stalled output holds the current
// byte, and the input register keeps the next instruction until the result
// register frees up.
`timescale 1ns / 1ps
module x86_64_instruction_encoder_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  x86enc_in_if.sink    req_i,
  x86enc_out_if.source rsp_o
);
  import x86enc_pkg::*;

  item_t in_q, in_d;
  logic  in_vld_q, in_vld_d;
  enc_t  enc;
  logic  enc_rdy;

  // The input register accepts whenever it is empty or hands its item on.
  assign req_i.ready = !in_vld_q || enc_rdy;

  always_comb begin
    in_d.opcode           = req_i.opcode;
    in_d.dst_reg          = req_i.dst_reg;
    in_d.src_reg          = req_i.src_reg;
    in_d.condition        = req_i.condition;
    in_d.immediate        = req_i.immediate;
    in_d.frame_offset     = req_i.frame_offset;
    in_d.rel_displacement = req_i.rel_displacement;
    if (req_i.ready) begin
      in_vld_d = req_i.valid;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= in_d;
    end
  end

  x86enc_encoder u_encoder (
    .item_i (in_q),
    .enc_o  (enc)
  );

  x86enc_serializer u_serializer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .enc_i     (enc),
    .enc_vld_i (in_vld_q),
    .enc_rdy_o (enc_rdy),
    .out_o     (rsp_o)
  );

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !enc_rdy) |=> (in_vld_q && $stable(in_q)))
    else $error("pending instruction lost while the result register was busy");

endmodule

@@ dv/x86enc_code_checker.sv @@
// Checker that predicts the machine code of every accepted instruction and compares each byte.
`timescale 1ns / 1ps
module x86enc_code_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  x86enc_in_if        req_mon_i,
  x86enc_out_if       rsp_mon_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_bytes_o
);
  import x86enc_pkg::*;

  localparam logic [7:0] RexR = 8'h04;
  localparam logic [7:0] RexB = 8'h01;

  // Low nibble of the condition code for setcc and jcc.
  localparam logic [7:0] CcNibble [8] = '{8'h04, 8'h04, 8'h05, 8'h05,
                                          8'h0C, 8'h0D, 8'h0E, 8'h0F};

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       error;
  } code_byte_t;

  code_byte_t  expected_code_q [$];
  logic [7:0]  enc_buf [$];
  int unsigned mismatches;

  function automatic logic [7:0] rex_of(input logic w, input logic [3:0] reg_f,
                                        input logic [3:0] rm_f);
    return REX_BASE | (w ? REX_W : 8'h00) | (reg_f[3] ? RexR : 8'h00)
           | (rm_f[3] ? RexB : 8'h00);
  endfunction

  function automatic logic [7:0] modrm_of(input logic [1:0] mode, input logic [3:0] reg_f,
                                          input logic [3:0] rm_f);
    return {mode, reg_f[2:0], rm_f[2:0]};
  endfunction

  function automatic void put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) enc_buf.push_back(v[8*i +: 8]);
  endfunction

  // rbp-based operand: disp8 when the offset fits in a signed byte, else disp32.
  function automatic void put_rbp_mem(input logic [3:0] reg_f, input logic signed [31:0] disp);
    if (disp >= -128 && disp <= 127) begin
      enc_buf.push_back(modrm_of(MOD_DISP8, reg_f, RM_RBP));
      put_le(64'(disp[7:0]), 1);
    end else begin
      enc_buf.push_back(modrm_of(MOD_DISP32, reg_f, RM_RBP));
      put_le(64'(disp), 4);
    end
  endfunction

  function automatic void put_reg_reg(input logic [7:0] opc, input logic [3:0] reg_f,
                                      input logic [3:0] rm_f);
    enc_buf.push_back(rex_of(1'b1, reg_f, rm_f));
    enc_buf.push_back(opc);
    enc_buf.push_back(modrm_of(MOD_REG, reg_f, rm_f));
  endfunction

  function automatic void encode_instruction(input item_t it);
    logic [3:0] d;
    logic [3:0] s;
    logic [7:0] cc;
    logic       reserved;
    d        = it.dst_reg;
    s        = it.src_reg;
    cc       = CcNibble[it.condition];
    reserved = 1'b0;
    enc_buf.delete();
    case (it.opcode)
      OP_MOV_IMM: begin
        enc_buf.push_back(rex_of(1'b1, 4'd0, d));
        enc_buf.push_back(OPC_MOV_IMM + {5'd0, d[2:0]});
        put_le(it.immediate, 8);
      end
      OP_MOV_RR: put_reg_reg(OPC_MOV_ST, s, d);
      OP_LOAD: begin
        enc_buf.push_back(rex_of(1'b1, d, RM_RBP));
        enc_buf.push_back(OPC_MOV_LD);
        put_rbp_mem(d, it.frame_offset);
      end
      OP_STORE: begin
        enc_buf.push_back(rex_of(1'b1, s, RM_RBP));
        enc_buf.push_back(OPC_MOV_ST);
        put_rbp_mem(s, it.frame_offset);
      end
      OP_LEA: begin
        enc_buf.push_back(rex_of(1'b1, d, RM_RBP));
        enc_buf.push_back(OPC_LEA);
        enc_buf.push_back(modrm_of(MOD_IND, d, RM_RBP));
        put_le(64'(it.rel_displacement), 4);
      end
      OP_PUSH: begin
        if (s[3]) enc_buf.push_back(REX_B_ONLY);
        enc_buf.push_back(OPC_PUSH + {5'd0, s[2:0]});
      end
      OP_POP: begin
        if (d[3]) enc_buf.push_back(REX_B_ONLY);
        enc_buf.push_back(OPC_POP + {5'd0, d[2:0]});
      end
      OP_ADD_IMM, OP_SUB_IMM: begin
        enc_buf.push_back(rex_of(1'b1, 4'd0, d));
        enc_buf.push_back(OPC_GRP1);
        enc_buf.push_back(modrm_of(MOD_REG,
                                   {1'b0, (it.opcode == OP_ADD_IMM) ? EXT_ADD : EXT_SUB}, d));
        put_le(64'(it.immediate[31:0]), 4);
      end
      OP_ADD_RR: put_reg_reg(OPC_ADD, s, d);
      OP_SUB_RR: put_reg_reg(OPC_SUB, s, d);
      OP_IMUL: begin
        enc_buf.push_back(rex_of(1'b1, d, s));
        enc_buf.push_back(OPC_ESCAPE);
        enc_buf.push_back(OPC_IMUL2);
        enc_buf.push_back(modrm_of(MOD_REG, d, s));
      end
      OP_CMP:  put_reg_reg(OPC_CMP, s, d);
      OP_TEST: put_reg_reg(OPC_TEST, s, d);
      OP_SETCC: begin
        // spl/bpl/sil/dil need a bare REX, or they would mean ah/ch/dh/bh.
        if (d[3:2] == 2'b01) enc_buf.push_back(REX_BASE);
        else if (d[3]) enc_buf.push_back(REX_B_ONLY);
        enc_buf.push_back(OPC_ESCAPE);
        enc_buf.push_back(OPC_SETCC + cc);
        enc_buf.push_back(modrm_of(MOD_REG, 4'd0, d));
        enc_buf.push_back(rex_of(1'b1, d, d));
        enc_buf.push_back(OPC_ESCAPE);
        enc_buf.push_back(OPC_MOVZX2);
        enc_buf.push_back(modrm_of(MOD_REG, d, d));
      end
      OP_NEG: begin
        enc_buf.push_back(rex_of(1'b1, 4'd0, d));
        enc_buf.push_back(OPC_GRP3);
        enc_buf.push_back(modrm_of(MOD_REG, {1'b0, EXT_NEG}, d));
      end
      OP_CQO: begin
        enc_buf.push_back(REX_W_ONLY);
        enc_buf.push_back(OPC_CQO);
      end
      OP_IDIV: begin
        enc_buf.push_back(rex_of(1'b1, 4'd0, s));
        enc_buf.push_back(OPC_GRP3);
        enc_buf.push_back(modrm_of(MOD_REG, {1'b0, EXT_IDV}, s));
      end
      OP_CALL: begin
        enc_buf.push_back(OPC_CALL);
        put_le(64'(it.rel_displacement), 4);
      end
      OP_JMP: begin
        enc_buf.push_back(OPC_JMP);
        put_le(64'(it.rel_displacement), 4);
      end
      OP_JCC: begin
        enc_buf.push_back(OPC_ESCAPE);
        enc_buf.push_back(OPC_JCC2 + cc);
        put_le(64'(it.rel_displacement), 4);
      end
      OP_RET: enc_buf.push_back(OPC_RET);
      OP_SYSCALL: begin
        enc_buf.push_back(OPC_ESCAPE);
        enc_buf.push_back(OPC_SYSCALL);
      end
      default: reserved = 1'b1;
    endcase
    if (reserved) begin
      expected_code_q.push_back('{code: 8'h00, last: 1'b1, error: 1'b1});
    end else begin
      foreach (enc_buf[i]) begin
        expected_code_q.push_back('{code: enc_buf[i], last: (i == enc_buf.size() - 1),
                                    error: 1'b0});
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    code_byte_t want;
    if (!rst_ni) begin
      expected_code_q.delete();
      mismatches = 0;
      mismatch_cnt_o  <= 0;
      pending_bytes_o <= 0;
    end else begin
      // Compare before predicting, so a byte that leaves too early is not matched.
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (expected_code_q.size() == 0) begin
          $error("unexpected byte %h (last %b, error %b)", rsp_mon_i.out_byte,
                 rsp_mon_i.last, rsp_mon_i.error);
          mismatches++;
        end else begin
          want = expected_code_q.pop_front();
          if (rsp_mon_i.out_byte !== want.code) begin
            $error("out_byte: expected %h, actual %h", want.code, rsp_mon_i.out_byte);
            mismatches++;
          end
          if (rsp_mon_i.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, rsp_mon_i.last);
            mismatches++;
          end
          if (rsp_mon_i.error !== want.error) begin
            $error("error: expected %b, actual %b", want.error, rsp_mon_i.error);
            mismatches++;
          end
        end
      end
      if (req_mon_i.valid && req_mon_i.ready) begin
        encode_instruction('{opcode: req_mon_i.opcode, dst_reg: req_mon_i.dst_reg,
                             src_reg: req_mon_i.src_reg, condition: req_mon_i.condition,
                             immediate: req_mon_i.immediate,
                             frame_offset: req_mon_i.frame_offset,
                             rel_displacement: req_mon_i.rel_displacement});
      end
      mismatch_cnt_o  <= mismatches;
      pending_bytes_o <= expected_code_q.size();
    end
  end

endmodule

@@ dv/tb_x86_64_instruction_encoder_top.sv @@
// Testbench top: clock, reset, instruction stimulus, output stalls and the final verdict.
`timescale 1ns / 1ps
module tb_x86_64_instruction_encoder_top;
  import x86enc_pkg::*;

  // Opcodes past syscall are reserved; these two bound that range.
  localparam logic [4:0] OpReservedFirst = 5'd23;
  localparam logic [4:0] OpReservedLast  = 5'd31;

  // Cycles without an accepted instruction before the run is declared hung. The
  // slowest correct stretch is a drain behind a ten-byte instruction under byte
  // stalls, far below this.
  localparam int unsigned HangLimit = 1000;
  localparam int unsigned RandomCount = 200;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        full_speed = 1'b0;
  int unsigned mismatch_cnt;
  int unsigned pending_bytes;
  int unsigned quiet_cycles;

  x86enc_in_if  req_if ();
  x86enc_out_if rsp_if ();

  x86_64_instruction_encoder_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // The checker sees both channels, predicts every byte and counts mismatches.
  x86enc_code_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_mon_i       (req_if),
    .rsp_mon_i       (rsp_if),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_bytes_o (pending_bytes)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The byte receiver drops ready at random, with a 23 percent chance, except during the
  // full-speed stretch, where it takes a byte on every cycle.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= rst_ni && (full_speed || ($urandom_range(99) >= 23));
    end
  end

  // Hang detection: count cycles in which no instruction is accepted, so a byte
  // stream that never ends cannot keep the run alive either.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t make_instruction(input logic [4:0] op, input logic [3:0] d,
                                             input logic [3:0] s, input logic [2:0] c,
                                             input logic [63:0] imm, input logic [31:0] fo,
                                             input logic [31:0] rel);
    return '{opcode: op, dst_reg: d, src_reg: s, condition: c, immediate: imm,
             frame_offset: fo, rel_displacement: rel};
  endfunction

  // Random instruction. Immediates and offsets lean toward their extremes and
  // toward the disp8/disp32 boundary; a few percent of the opcodes are reserved.
  function automatic item_t random_instruction();
    logic [4:0]  op;
    logic [63:0] imm;
    logic [31:0] fo;
    op = ($urandom_range(99) < 8) ? 5'($urandom_range(OpReservedLast, OpReservedFirst))
                                  : 5'($urandom_range(OP_SYSCALL));
    case ($urandom_range(5))
      0:       imm = 64'h8000_0000_0000_0000;
      1:       imm = 64'h7FFF_FFFF_FFFF_FFFF;
      2:       imm = 64'(int'($urandom_range(511)) - 256);
      default: imm = {$urandom, $urandom};
    endcase
    case ($urandom_range(3))
      0:       fo = $urandom;
      1:       fo = ($urandom_range(1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: fo = 32'(int'($urandom_range(511)) - 256);
    endcase
    return make_instruction(op, 4'($urandom_range(15)), 4'($urandom_range(15)),
                            3'($urandom_range(7)), imm, fo, $urandom);
  endfunction

  // Offers one instruction, holds it until the transaction happens, then may drop
  // valid outside the full-speed stretch. Valid is only lowered in a cycle of its own, so
  // back-to-back instructions keep it high without a glitch.
  task automatic send_instruction(input item_t it);
    req_if.valid            <= 1'b1;
    req_if.opcode           <= it.opcode;
    req_if.dst_reg          <= it.dst_reg;
    req_if.src_reg          <= it.src_reg;
    req_if.condition        <= it.condition;
    req_if.immediate        <= it.immediate;
    req_if.frame_offset     <= it.frame_offset;
    req_if.rel_displacement <= it.rel_displacement;
    do @(posedge clk_i); while (!req_if.ready);
    if (!full_speed) begin
      while ($urandom_range(99) < 23) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  // Drops valid and waits until the checker holds no outstanding byte. The first
  // edge lets the checker register the instruction that was just accepted.
  task automatic drain_encoder();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_bytes != 0);
  endtask

  initial begin
    req_if.valid            <= 1'b0;
    req_if.opcode           <= '0;
    req_if.dst_reg          <= '0;
    req_if.src_reg          <= '0;
    req_if.condition        <= '0;
    req_if.immediate        <= '0;
    req_if.frame_offset     <= '0;
    req_if.rel_displacement <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every instruction kind at least once, the field extremes, both
    // displacement sizes at their boundary, the forced REX of setcc on the
    // byte registers spl..dil, the high-register prefixes, and reserved opcodes.
    send_instruction(make_instruction(OP_MOV_IMM, 4'd0, 4'd0, 3'd0,
                                      64'h8000_0000_0000_0000, 32'd0, 32'd0));
    send_instruction(make_instruction(OP_MOV_IMM, 4'd15, 4'd15, 3'd7,
                                      64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_instruction(make_instruction(OP_MOV_RR, 4'd15, 4'd0, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_LOAD, 4'd8, 4'd0, 3'd0, '0, 32'sd127, '0));
    send_instruction(make_instruction(OP_LOAD, 4'd0, 4'd0, 3'd0, '0, -32'sd129, '0));
    send_instruction(make_instruction(OP_STORE, 4'd0, 4'd15, 3'd0, '0, -32'sd128, '0));
    send_instruction(make_instruction(OP_STORE, 4'd0, 4'd3, 3'd0, '0, 32'sd128, '0));
    send_instruction(make_instruction(OP_LEA, 4'd12, 4'd0, 3'd0, '0, '0, 32'h8000_0000));
    send_instruction(make_instruction(OP_PUSH, 4'd0, 4'd15, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_POP, 4'd4, 4'd0, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_ADD_IMM, 4'd9, 4'd0, 3'd0, '1, '0, '0));
    send_instruction(make_instruction(OP_SUB_IMM, 4'd2, 4'd0, 3'd0,
                                      64'h0000_0000_7FFF_FFFF, '0, '0));
    send_instruction(make_instruction(OP_ADD_RR, 4'd1, 4'd10, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_SUB_RR, 4'd14, 4'd6, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_IMUL, 4'd15, 4'd15, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_CMP, 4'd7, 4'd8, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_TEST, 4'd11, 4'd3, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_SETCC, 4'd5, 4'd0, 3'd7, '0, '0, '0));
    send_instruction(make_instruction(OP_SETCC, 4'd13, 4'd0, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_SETCC, 4'd2, 4'd0, 3'd4, '0, '0, '0));
    send_instruction(make_instruction(OP_NEG, 4'd11, 4'd0, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_CQO, 4'd0, 4'd0, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_IDIV, 4'd0, 4'd14, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_CALL, 4'd0, 4'd0, 3'd0, '0, '0, 32'h7FFF_FFFF));
    send_instruction(make_instruction(OP_JMP, 4'd0, 4'd0, 3'd0, '0, '0, 32'hFFFF_FFFF));
    send_instruction(make_instruction(OP_JCC, 4'd0, 4'd0, 3'd2, '0, '0, 32'h0000_0080));
    send_instruction(make_instruction(OP_RET, 4'd0, 4'd0, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OP_SYSCALL, 4'd0, 4'd0, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OpReservedFirst, 4'd0, 4'd0, 3'd0, '0, '0, '0));
    send_instruction(make_instruction(OpReservedLast, 4'd15, 4'd15, 3'd7, '1, '1, '1));
    drain_encoder();

    // Random part. A second full drain sits a quarter of the way in, and a stretch of
    // instructions runs with neither side idling.
    for (int n = 0; n < RandomCount; n++) begin
      if (n == RandomCount / 4) drain_encoder();
      full_speed <= (n >= RandomCount / 2) && (n < RandomCount * 3 / 4);
      send_instruction(random_instruction());
    end

    // Wait for every predicted byte, then keep the clock running to catch strays.
    drain_encoder();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/x86enc_pkg.sv
rtl/x86enc_if.sv
rtl/x86enc_encoder.sv
rtl/x86enc_serializer.sv
rtl/x86_64_instruction_encoder_top.sv
dv/x86enc_code_checker.sv
dv/tb_x86_64_instruction_encoder_top.sv
